// ===== rtl/ipc_pkg.sv =====
// Shared types, character codes and helper functions for the infix to postfix converter.
// Depends on nothing; every other file of the block depends on it.
package ipc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [7:0]        sym_t;
  typedef logic signed [2:0] prec_t;

  localparam sym_t CH_CARET  = 8'h5E;
  localparam sym_t CH_STAR   = 8'h2A;
  localparam sym_t CH_SLASH  = 8'h2F;
  localparam sym_t CH_PLUS   = 8'h2B;
  localparam sym_t CH_MINUS  = 8'h2D;
  localparam sym_t CH_LPAREN = 8'h28;
  localparam sym_t CH_RPAREN = 8'h29;
  localparam sym_t CH_LC_A   = 8'h61;
  localparam sym_t CH_LC_Z   = 8'h7A;
  localparam sym_t CH_UC_A   = 8'h41;
  localparam sym_t CH_UC_Z   = 8'h5A;
  localparam sym_t CH_DIG_0  = 8'h30;
  localparam sym_t CH_DIG_9  = 8'h39;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_OPEN  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_END,
    S_DRAIN,
    S_FIN
  } ipc_state_t;

  // request from the sequencer to the result stage
  typedef struct packed {
    logic       push;
    logic       fin;
    logic       expr_done;
    sym_t       sym;
    logic       sym_valid;
    logic [1:0] status;
  } res_req_t;

  // result stage occupancy seen by the sequencer
  typedef struct packed {
    logic room;
    logic out_free;
    logic pend_valid;
  } res_stat_t;

  function automatic prec_t prec_of(sym_t ch);
    prec_t p;
    p = -3'sd1;
    case (ch)
      CH_CARET:           p = 3'sd3;
      CH_STAR, CH_SLASH:  p = 3'sd2;
      CH_PLUS, CH_MINUS:  p = 3'sd1;
      default:            p = -3'sd1;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(sym_t ch);
    return ((ch >= CH_LC_A) && (ch <= CH_LC_Z)) ||
           ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
           ((ch >= CH_DIG_0) && (ch <= CH_DIG_9));
  endfunction

endpackage

// ===== rtl/ipc_if.sv =====
// Valid/ready channel interfaces for the infix to postfix converter.
// Depends on ipc_pkg for the symbol type.
interface ipc_in_if;
  logic            valid;
  logic            ready;
  ipc_pkg::sym_t   symbol_in;
  logic            expr_end;

  modport source (output valid, output symbol_in, output expr_end, input ready);
  modport sink   (input valid, input symbol_in, input expr_end, output ready);
endinterface

interface ipc_out_if;
  logic            valid;
  logic            ready;
  ipc_pkg::sym_t   symbol_out;
  logic            symbol_valid;
  logic [1:0]      status;
  logic            run_last;
  logic            expr_done;

  modport source (output valid, output symbol_out, output symbol_valid, output status,
                  output run_last, output expr_done, input ready);
  modport sink   (input valid, input symbol_out, input symbol_valid, input status,
                  input run_last, input expr_done, output ready);
endinterface

// ===== rtl/ipc_stack_mem.sv =====
// Operator stack storage: one write port, one read port, registered read data.
// Depends on ipc_pkg for depth and address width.
module ipc_stack_mem (
  input  logic           clk,
  input  logic           wr_en,
  input  ipc_pkg::addr_t wr_addr,
  input  ipc_pkg::sym_t  wr_data,
  input  logic           rd_en,
  input  ipc_pkg::addr_t rd_addr,
  output ipc_pkg::sym_t  rd_data
);
  import ipc_pkg::*;

  sym_t mem [STACK_DEPTH];
  sym_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

// ===== rtl/ipc_ctrl.sv =====
// Shunting-yard sequencer: classifies each item, pops and pushes the stack memory.
// Depends on ipc_pkg, ipc_if and the stack memory read data.
module ipc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  ipc_in_if.sink              in_ch,
  input  ipc_pkg::sym_t       top_data,
  output logic                wr_en,
  output ipc_pkg::addr_t      wr_addr,
  output ipc_pkg::sym_t       wr_data,
  output logic                rd_en,
  output ipc_pkg::addr_t      rd_addr,
  output ipc_pkg::res_req_t   req,
  input  ipc_pkg::res_stat_t  stat
);
  import ipc_pkg::*;

  ipc_state_t state_r, state_nxt;
  cnt_t       cnt_r, cnt_nxt;
  sym_t       ch_r;
  logic       last_r;

  logic       empty, full, accept;
  addr_t      top_addr, next_addr;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == CNT_W'(STACK_DEPTH));
  assign top_addr  = ADDR_W'(cnt_r - CNT_W'(1));
  assign next_addr = ADDR_W'(cnt_r - CNT_W'(2));
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r   <= in_ch.symbol_in;
      last_r <= in_ch.expr_end;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = ADDR_W'(cnt_r);
    wr_data   = ch_r;
    rd_en     = 1'b0;
    rd_addr   = top_addr;
    req       = '0;
    req.status = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (is_alnum(ch_r)) begin
          if (stat.room) begin
            req.push      = 1'b1;
            req.sym       = ch_r;
            req.sym_valid = 1'b1;
            state_nxt     = S_END;
          end
        end else if (ch_r == CH_RPAREN) begin
          if (empty) begin
            if (stat.room) begin
              req.push   = 1'b1;
              req.status = ST_NO_OPEN;
              state_nxt  = S_END;
            end
          end else if (top_data == CH_LPAREN) begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_END;
          end else if (stat.room) begin
            req.push      = 1'b1;
            req.sym       = top_data;
            req.sym_valid = 1'b1;
            cnt_nxt       = cnt_r - CNT_W'(1);
            rd_en         = 1'b1;
            rd_addr       = next_addr;
          end
        end else if ((ch_r != CH_LPAREN) && !empty &&
                     (prec_of(ch_r) <= prec_of(top_data))) begin
          if (stat.room) begin
            req.push      = 1'b1;
            req.sym       = top_data;
            req.sym_valid = 1'b1;
            cnt_nxt       = cnt_r - CNT_W'(1);
            rd_en         = 1'b1;
            rd_addr       = next_addr;
          end
        end else if (full) begin
          if (stat.room) begin
            req.push   = 1'b1;
            req.status = ST_OVERFLOW;
            state_nxt  = S_END;
          end
        end else begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_END;
        end
      end

      S_END: begin
        if (last_r && !empty) begin
          rd_en     = 1'b1;
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_DRAIN: begin
        if (stat.room) begin
          req.push      = 1'b1;
          req.sym       = top_data;
          req.sym_valid = 1'b1;
          cnt_nxt       = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = next_addr;
          end
        end
      end

      S_FIN: begin
        if (!stat.pend_valid && !last_r) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          req.fin       = 1'b1;
          req.expr_done = last_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/ipc_out_stage.sv =====
// Result stage: one pending item that waits to learn if it is last, then the output register.
// Depends on ipc_pkg and ipc_if.
module ipc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  ipc_pkg::res_req_t   req,
  output ipc_pkg::res_stat_t  stat,
  ipc_out_if.source           out_ch
);
  import ipc_pkg::*;

  logic       out_valid_r;
  sym_t       out_sym_r;
  logic       out_sv_r;
  logic [1:0] out_st_r;
  logic       out_last_r;
  logic       out_done_r;

  logic       pend_valid_r;
  sym_t       pend_sym_r;
  logic       pend_sv_r;
  logic [1:0] pend_st_r;

  logic       out_free;

  assign out_free        = !out_valid_r || out_ch.ready;
  assign stat.out_free   = out_free;
  assign stat.room       = !pend_valid_r || out_free;
  assign stat.pend_valid = pend_valid_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol_out   = out_sym_r;
  assign out_ch.symbol_valid = out_sv_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.run_last     = out_last_r;
  assign out_ch.expr_done    = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (req.push) begin
        pend_valid_r <= 1'b1;
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
        end
      end
      if (req.fin) begin
        pend_valid_r <= 1'b0;
        if (pend_valid_r || req.expr_done) begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      pend_sym_r <= req.sym;
      pend_sv_r  <= req.sym_valid;
      pend_st_r  <= req.status;
      if (pend_valid_r) begin
        out_sym_r  <= pend_sym_r;
        out_sv_r   <= pend_sv_r;
        out_st_r   <= pend_st_r;
        out_last_r <= 1'b0;
        out_done_r <= 1'b0;
      end
    end
    if (req.fin) begin
      out_last_r <= 1'b1;
      out_done_r <= req.expr_done;
      if (pend_valid_r) begin
        out_sym_r <= pend_sym_r;
        out_sv_r  <= pend_sv_r;
        out_st_r  <= pend_st_r;
      end else begin
        out_sym_r <= '0;
        out_sv_r  <= 1'b0;
        out_st_r  <= ST_OK;
      end
    end
  end
endmodule

// ===== rtl/infix_to_postfix_converter_top.sv =====
// Top level of the infix to postfix converter: sequencer, stack memory, result stage.
// Depends on ipc_pkg, ipc_if, ipc_stack_mem, ipc_ctrl and ipc_out_stage.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    symbol_in[7:0], expr_end
//   out_ch    out   valid / ready    symbol_out[7:0], symbol_valid, status[1:0],
//                                    run_last, expr_done
//
// One item at a time: on accept the stack top is read, the sequencer then handles the
// item, with a further stack read per popped entry, then checks whether a drain starts,
// pops each drained entry in turn and closes the item.
// Reset clears the sequencer, stack count, pending valid and output valid; stack contents are kept.
// A stalled output holds the sequencer once the pending item and the output are full.
module infix_to_postfix_converter_top (
  input  logic      clk,
  input  logic      rst_n,
  ipc_in_if.sink    in_ch,
  ipc_out_if.source out_ch
);
  import ipc_pkg::*;

  logic      wr_en, rd_en;
  addr_t     wr_addr, rd_addr;
  sym_t      wr_data, rd_data;
  res_req_t  req;
  res_stat_t stat;

  ipc_stack_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .top_data (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .req      (req),
    .stat     (stat)
  );

  ipc_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .stat   (stat),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    req.push |-> stat.room) else $error("result pushed without room");

  a_fin_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    req.fin |-> stat.out_free) else $error("item closed while output busy");

  a_push_fin_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.push && req.fin)) else $error("push and close in one cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.expr_done) |-> out_ch.run_last)
    else $error("expression end not on last result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while busy");
`endif
endmodule
